FILE: src/generational_handle_allocator_core_assert.svh
// Assertion macros shared by the handle allocator RTL.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GHA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("handle allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("handle allocator assertion failed");

`endif

FILE: src/gha_pkg.sv
// Types and constants for the generational handle allocator.
package gha_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned VER_W   = 32;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned LIVE_W  = 11;

  localparam logic [INDEX_W-1:0] INVALID_INDEX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CHECK  = 2'd2
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_HANDLE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

endpackage

FILE: src/gha_ifs.sv
// Request and response channel interfaces of the handle allocator.
interface gha_req_if import gha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [INDEX_W-1:0] handle_index;
  logic [VER_W-1:0]   handle_version;

  modport source (output valid, output cmd, output handle_index, output handle_version,
                  input ready);
  modport sink (input valid, input cmd, input handle_index, input handle_version,
                output ready);
endinterface

interface gha_rsp_if import gha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] out_index;
  logic [VER_W-1:0]   out_version;
  logic               handle_ok;
  logic [ST_W-1:0]    status;
  logic [LIVE_W-1:0]  live_count;

  modport source (output valid, output out_index, output out_version, output handle_ok,
                  output status, output live_count, input ready);
  modport sink (input valid, input out_index, input out_version, input handle_ok,
                input status, input live_count, output ready);
endinterface

FILE: src/gha_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module gha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/generational_handle_allocator_core.sv
// Generational handle allocator: slot table and LIFO free stack in block RAM.
//
//   channel | direction | transaction
//   req     | in        | cmd, handle_index, handle_version
//   rsp     | out       | out_index, out_version, handle_ok, status, live_count
//
// Each command is accepted, then executed: the accept cycle reads the slot table
// and the top of the free stack, and the execute cycle computes and writes both RAMs.
// The free stack keeps the bumped version with each freed index, so a reuse
// needs no second read of the slot table. The response register lets the next
// command be accepted while a response waits; a stalled response holds the
// execute cycle. Synchronous reset clears state, counters and rsp_valid; no RAM clearing pass.
module generational_handle_allocator_core import gha_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 1024
) (
  input logic        clk,
  input logic        rst,
  gha_req_if.sink    req,
  gha_rsp_if.source  rsp
);

  localparam int unsigned IDX_W  = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned SLOT_W = VER_W + 1;
  localparam int unsigned STK_W  = IDX_W + VER_W;

  state_t state, state_next;

  logic [CNT_W-1:0] slots_used, slots_used_next;
  logic [CNT_W-1:0] free_depth, free_depth_next;

  cmd_t               cmd_q;
  logic [INDEX_W-1:0] idx_q;
  logic [VER_W-1:0]   ver_q;

  logic               rsp_valid;
  logic [INDEX_W-1:0] rsp_index, rsp_index_next;
  logic [VER_W-1:0]   rsp_version, rsp_version_next;
  logic               rsp_ok, rsp_ok_next;
  status_t            rsp_status, rsp_status_next;
  logic [LIVE_W-1:0]  rsp_live, rsp_live_next;

  logic accept;
  logic exec_go;

  // Slot table entry: live flag on top of the version.
  logic              slot_we, slot_we_raw;
  logic [IDX_W-1:0]  slot_waddr;
  logic [SLOT_W-1:0] slot_wdata;
  logic [SLOT_W-1:0] slot_rdata;

  // Free stack entry: freed index with the version it was left at.
  logic              stk_we, stk_we_raw;
  logic [IDX_W-1:0]  stk_waddr;
  logic [STK_W-1:0]  stk_wdata;
  logic [STK_W-1:0]  stk_rdata;
  logic [IDX_W-1:0]  stk_raddr;
  logic [CNT_W-1:0]  depth_minus_one;

  logic             slot_live;
  logic [VER_W-1:0] slot_ver;
  logic [IDX_W-1:0] top_idx;
  logic [VER_W-1:0] top_ver;
  logic [VER_W-1:0] bumped_ver;
  logic             match;
  logic [CNT_W-1:0] live_diff;

  // Control outputs.
  always_comb begin
    req.ready = (state == S_IDLE);
    accept    = req.valid && (state == S_IDLE);
    exec_go   = (state == S_EXEC) && (!rsp_valid || rsp.ready);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign depth_minus_one = free_depth - CNT_W'(1);
  assign stk_raddr       = depth_minus_one[IDX_W-1:0];

  gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (req.handle_index[IDX_W-1:0]),
    .rdata (slot_rdata)
  );

  gha_ram #(.WIDTH(STK_W), .DEPTH(SLOT_COUNT)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign slot_live  = slot_rdata[VER_W];
  assign slot_ver   = slot_rdata[VER_W-1:0];
  assign top_idx    = stk_rdata[STK_W-1:VER_W];
  assign top_ver    = stk_rdata[VER_W-1:0];
  assign bumped_ver = slot_ver + VER_W'(1);
  // Slots at or above the fill mark were never written, so the range test
  // comes first and masks their contents.
  assign match = (idx_q < INDEX_W'(slots_used)) && slot_live && (slot_ver == ver_q);

  // Execute cycle: decide the command and form the RAM writes.
  always_comb begin
    slots_used_next  = slots_used;
    free_depth_next  = free_depth;
    rsp_index_next   = '0;
    rsp_version_next = '0;
    rsp_ok_next      = 1'b0;
    rsp_status_next  = ST_OK;
    slot_we_raw      = 1'b0;
    slot_waddr       = idx_q[IDX_W-1:0];
    slot_wdata       = '0;
    stk_we_raw       = 1'b0;
    stk_waddr        = free_depth[IDX_W-1:0];
    stk_wdata        = {idx_q[IDX_W-1:0], bumped_ver};
    case (cmd_q)
      CMD_CREATE: begin
        if (free_depth != '0) begin
          free_depth_next  = depth_minus_one;
          slot_we_raw      = 1'b1;
          slot_waddr       = top_idx;
          slot_wdata       = {1'b1, top_ver + VER_W'(1)};
          rsp_index_next   = INDEX_W'(top_idx);
          rsp_version_next = top_ver + VER_W'(1);
        end else if (slots_used < CNT_W'(SLOT_COUNT)) begin
          slots_used_next = slots_used + CNT_W'(1);
          slot_we_raw     = 1'b1;
          slot_waddr      = slots_used[IDX_W-1:0];
          slot_wdata      = {1'b1, {VER_W{1'b0}}};
          rsp_index_next  = INDEX_W'(slots_used);
        end else begin
          rsp_status_next = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (match && (free_depth < CNT_W'(SLOT_COUNT))) begin
          free_depth_next  = free_depth + CNT_W'(1);
          slot_we_raw      = 1'b1;
          slot_wdata       = {1'b0, bumped_ver};
          stk_we_raw       = 1'b1;
          rsp_index_next   = INVALID_INDEX;
          rsp_version_next = bumped_ver;
        end else begin
          rsp_status_next = ST_BAD_HANDLE;
        end
      end
      CMD_CHECK: begin
        rsp_ok_next = match;
      end
      default: begin
      end
    endcase
    live_diff     = slots_used_next - free_depth_next;
    rsp_live_next = LIVE_W'(live_diff);
    slot_we       = slot_we_raw && exec_go;
    stk_we        = stk_we_raw && exec_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slots_used <= '0;
      free_depth <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_go) begin
        slots_used <= slots_used_next;
        free_depth <= free_depth_next;
        rsp_valid  <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd_t'(req.cmd);
      idx_q <= req.handle_index;
      ver_q <= req.handle_version;
    end
    if (exec_go) begin
      rsp_index   <= rsp_index_next;
      rsp_version <= rsp_version_next;
      rsp_ok      <= rsp_ok_next;
      rsp_status  <= rsp_status_next;
      rsp_live    <= rsp_live_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.out_index   = rsp_index;
  assign rsp.out_version = rsp_version;
  assign rsp.handle_ok   = rsp_ok;
  assign rsp.status      = rsp_status;
  assign rsp.live_count  = rsp_live;

  `include "generational_handle_allocator_core_assert.svh"

  `GHA_ASSERT_SAME(a_depth_le_used, 1'b1, free_depth <= slots_used)
  `GHA_ASSERT_SAME(a_used_le_count, 1'b1, slots_used <= CNT_W'(SLOT_COUNT))
  `GHA_ASSERT_NEXT(a_accept_exec, req.valid && req.ready, state == S_EXEC)
  `GHA_ASSERT_NEXT(a_exec_loads_rsp, exec_go, rsp.valid && (state == S_IDLE))

endmodule
